>>> rtl/core/sha256_pkg.sv
// ============================================================================
// SHA-256 package
// Shared types, constants and the rotate function for the SHA-256 stream hasher.
// ============================================================================
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       load;     // copy chain into working vars, clear round count
    logic       round;    // run one round
    logic       fold;     // add working vars into chain
    logic       pad_sel;  // read padded block instead of raw block
    logic       second;   // which padding block is being compressed
    logic       chain_rst;
  } cmd_t;

  typedef struct packed {
    logic rounds_done;
  } stat_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] START_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

>>> rtl/core/sha256_ctrl.sv
// ============================================================================
// SHA-256 controller
// Sequences byte collection, block compression, padding and digest output.
// ============================================================================
module sha256_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic              in_byte,
  input  logic              in_end,
  input  logic [5:0]        fill,
  input  sha256_pkg::stat_t stat,
  input  logic              out_fire,
  input  logic              out_last,
  output sha256_pkg::cmd_t  cmd,
  output logic              in_ready,
  output logic              out_valid
);

  sha256_pkg::state_t state, state_next;
  logic pad_mode, pad_mode_next;   // compressing padding blocks
  logic second, second_next;       // second padding block pending/active
  logic two_blk, two_blk_next;     // padding needs two blocks

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha256_pkg::ST_COLLECT;
      pad_mode <= 1'b0;
      second <= 1'b0;
      two_blk <= 1'b0;
    end else begin
      state <= state_next;
      pad_mode <= pad_mode_next;
      second <= second_next;
      two_blk <= two_blk_next;
    end
  end

  always_comb begin
    state_next = state;
    pad_mode_next = pad_mode;
    second_next = second;
    two_blk_next = two_blk;
    unique case (state)
      sha256_pkg::ST_COLLECT: begin
        if (in_fire) begin
          if (in_byte && fill == 6'd63) begin
            state_next = sha256_pkg::ST_LOAD;
            pad_mode_next = 1'b0;
            second_next = 1'b0;
            two_blk_next = in_end;
          end else if (in_end) begin
            state_next = sha256_pkg::ST_LOAD;
            pad_mode_next = 1'b1;
            second_next = 1'b0;
            // Fill after this byte decides the block count.
            two_blk_next = ((in_byte ? fill + 6'd1 : fill) >= 6'd56);
          end
        end
      end
      sha256_pkg::ST_LOAD:  state_next = sha256_pkg::ST_ROUND;
      sha256_pkg::ST_ROUND: if (stat.rounds_done) state_next = sha256_pkg::ST_FOLD;
      sha256_pkg::ST_FOLD: begin
        if (!pad_mode) begin
          // A full block ended with the message end: pad an empty tail.
          if (two_blk) begin
            pad_mode_next = 1'b1;
            two_blk_next = 1'b0;
            second_next = 1'b0;
            state_next = sha256_pkg::ST_LOAD;
          end else begin
            state_next = sha256_pkg::ST_COLLECT;
          end
        end else if (two_blk && !second) begin
          second_next = 1'b1;
          state_next = sha256_pkg::ST_LOAD;
        end else begin
          state_next = sha256_pkg::ST_EMIT;
        end
      end
      sha256_pkg::ST_EMIT: begin
        if (out_fire && out_last) begin
          state_next = sha256_pkg::ST_COLLECT;
          pad_mode_next = 1'b0;
          second_next = 1'b0;
          two_blk_next = 1'b0;
        end
      end
      default: state_next = sha256_pkg::ST_COLLECT;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    cmd.pad_sel = pad_mode;
    cmd.second = second;
    unique case (state)
      sha256_pkg::ST_COLLECT: in_ready = 1'b1;
      sha256_pkg::ST_LOAD:    cmd.load = 1'b1;
      sha256_pkg::ST_ROUND:   cmd.round = 1'b1;
      sha256_pkg::ST_FOLD:    cmd.fold = 1'b1;
      sha256_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        cmd.chain_rst = out_fire && out_last;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/sha256_dp.sv
// ============================================================================
// SHA-256 datapath
// Block store, message schedule window, round logic and chaining words.
// ============================================================================
module sha256_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic              in_byte,
  input  logic [7:0]        data_byte,
  input  logic              in_end,
  input  sha256_pkg::cmd_t  cmd,
  input  logic              out_fire,
  output sha256_pkg::stat_t stat,
  output logic [5:0]        fill,
  output logic [31:0]       digest_word,
  output logic [2:0]        word_index,
  output logic              last_word
);

  logic [31:0] store [16];    // block bytes, big-endian within each word
  logic [5:0]  tail_n;        // pending bytes when padding starts
  logic [60:0] total;
  logic [60:0] len_q;         // length latched at message end
  logic [31:0] chain [8];
  logic [31:0] v [8];
  logic [31:0] w [16];
  logic [5:0]  rnd;
  logic [2:0]  oidx;

  // Byte at position p of the block being compressed (raw or padded).
  function automatic logic [7:0] blk_byte(input logic [5:0] p, input logic pad,
                                          input logic sec, input logic [5:0] n,
                                          input logic [63:0] bits,
                                          input logic [7:0] raw);
    logic       two;
    logic [7:0] b;
    begin
      two = (n >= 6'd56);
      b = 8'h00;
      if (!pad) b = raw;
      else begin
        if (!sec) begin
          if (p < n) b = raw;
          else if (p == n) b = sha256_pkg::PAD_BYTE;
        end
        if ((sec || !two) && p >= 6'd56)
          b = bits[8*(7-(p-6'd56)) +: 8];
      end
      blk_byte = b;
    end
  endfunction

  logic [63:0]  bitlen;
  logic [31:0]  w_in;
  logic [31:0]  w_cur, w_new, s0, s1;
  logic [31:0]  t1, t2;
  logic [5:0]   fill_next_v;

  assign bitlen = {len_q, 3'b000};

  // One store word per round feeds the first sixteen schedule words.
  always_comb begin
    logic [31:0] raw_w;
    raw_w = store[rnd[3:0]];
    for (int j = 0; j < 4; j++)
      w_in[31-8*j -: 8] = blk_byte({rnd[3:0], 2'(j)}, cmd.pad_sel, cmd.second, tail_n,
                                   bitlen, raw_w[31-8*j -: 8]);
  end

  always_comb begin
    s0 = sha256_pkg::rotr(w[1], 7) ^ sha256_pkg::rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = sha256_pkg::rotr(w[14], 17) ^ sha256_pkg::rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + s0 + w[9] + s1;
    w_cur = (rnd < 6'd16) ? w_in : w_new;
    t1 = v[7] + (sha256_pkg::rotr(v[4], 6) ^ sha256_pkg::rotr(v[4], 11)
               ^ sha256_pkg::rotr(v[4], 25))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::ROUND_K[rnd] + w_cur;
    t2 = (sha256_pkg::rotr(v[0], 2) ^ sha256_pkg::rotr(v[0], 13)
        ^ sha256_pkg::rotr(v[0], 22))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  assign fill_next_v = fill + 6'd1;
  assign stat.rounds_done = (rnd == 6'd63);

  always_ff @(posedge clk) begin
    if (in_fire && in_byte) store[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= data_byte;
    if (cmd.load) begin
      for (int i = 0; i < 8; i++) v[i] <= chain[i];
    end
    if (cmd.round) begin
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      total <= '0;
      tail_n <= '0;
      len_q <= '0;
      rnd <= '0;
      oidx <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= sha256_pkg::START_H[i];
    end else begin
      if (in_fire) begin
        if (in_byte) begin
          fill <= fill_next_v;
          total <= total + 61'd1;
        end
        if (in_end) begin
          len_q <= total + (in_byte ? 61'd1 : 61'd0);
          tail_n <= in_byte ? fill_next_v : fill;
        end
      end
      if (cmd.load) rnd <= '0;
      else if (cmd.round) rnd <= rnd + 6'd1;
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
      end
      // The index wraps to zero as the eighth word is taken.
      if (out_fire) oidx <= oidx + 3'd1;
      if (cmd.chain_rst) begin
        for (int i = 0; i < 8; i++) chain[i] <= sha256_pkg::START_H[i];
        fill <= '0;
        total <= '0;
      end
    end
  end

  assign digest_word = chain[oidx];
  assign word_index = oidx;
  assign last_word = (oidx == 3'd7);

endmodule

>>> rtl/core/sha256_stream_hasher_top.sv
// ============================================================================
// SHA-256 stream hasher, top level
// Hashes a byte stream with SHA-256 and emits the eight digest words.
// ============================================================================
//
//  channel | dir | tdata                      | tuser      | tlast
//  s_axis  | in  | [7:0] data_byte            | byte_valid | msg_end
//  m_axis  | out | [31:0] digest_word         | word_index | last_word
//
// Byte words are taken while bytes collect. The 64th byte of a
// block starts compression: a load, the rounds and a fold, all on the
// single shared round unit, during which input is held off. A message end
// adds one or two padding blocks and then eight output words, one per cycle
// when the sink is ready. Reset is synchronous and returns the chaining
// words and counters to their initial values. A stalled output holds its
// word until it is taken.
module sha256_stream_hasher_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] byte_valid
  input  logic        s_axis_tlast,   // msg_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output logic        m_axis_tlast    // last_word
);

  sha256_pkg::cmd_t  cmd;
  sha256_pkg::stat_t stat;
  logic [5:0] fill;
  logic in_fire, out_fire;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  sha256_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_byte(s_axis_tuser),
    .in_end(s_axis_tlast), .fill(fill), .stat(stat), .out_fire(out_fire),
    .out_last(m_axis_tlast), .cmd(cmd), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid)
  );

  sha256_dp u_dp (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_byte(s_axis_tuser),
    .data_byte(s_axis_tdata), .in_end(s_axis_tlast), .cmd(cmd),
    .out_fire(out_fire), .stat(stat), .fill(fill), .digest_word(m_axis_tdata),
    .word_index(m_axis_tuser), .last_word(m_axis_tlast)
  );

endmodule

>>> rtl/core/sha256_checker.sv
// ============================================================================
// SHA-256 port checker
// Watches the top-level ports for output ordering, stall hold and exclusivity.
// ============================================================================
module sha256_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("input and output both open");

  a_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)))
    else $error("last flag off word seven");

  a_step: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1))
    else $error("digest word skipped");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("stalled word changed");

endmodule

bind sha256_stream_hasher_top sha256_checker u_chk (
  .clk(clk), .rst(rst), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
  .m_axis_tlast(m_axis_tlast)
);

>>> test/tb_sha256_stream_hasher_top.sv
// ============================================================================
// SHA-256 stream hasher testbench
// Streams messages of varied length into the hasher and checks every digest
// word against a cycle-free SHA-256 predictor kept inside the bench.
// ============================================================================
module tb_sha256_stream_hasher_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       msg_end;
  } byte_item_t;

  typedef struct {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  byte_item_t  word_backlog[$];
  digest_out_t digest_expect[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          item_total = 0;
  int          msg_total = 0;

  // Predictor state: chaining words, partial block and running byte length.
  logic [31:0] hash_chain [8];
  logic [7:0]  hash_block [64];
  int          hash_fill;
  logic [60:0] hash_bytes;

  sha256_stream_hasher_top dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One 64-round compression of a 64-byte block into the chaining words.
  function automatic void compress_block(input logic [7:0] blk [64]);
    logic [31:0] sched [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      sched[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      sched[i] = sched[i-16] + sched[i-7]
               + (ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3))
               + (ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = hash_chain[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::ROUND_K[i] + sched[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_chain[i] += v[i];
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++) hash_chain[i] = sha256_pkg::START_H[i];
    hash_fill = 0;
    hash_bytes = '0;
  endfunction

  // Absorbs one accepted word; a message end pads, finishes and queues the digest.
  function automatic void absorb_word(input byte_item_t it);
    logic [7:0]  tail [128];
    logic [7:0]  half [64];
    logic [63:0] bit_len;
    int          two_blocks;
    digest_out_t d;
    if (it.byte_valid) begin
      hash_block[hash_fill] = it.data_byte;
      hash_fill++;
      hash_bytes++;
      if (hash_fill == 64) begin
        compress_block(hash_block);
        hash_fill = 0;
      end
    end
    if (!it.msg_end) return;
    two_blocks = (hash_fill >= 56);
    bit_len = {hash_bytes, 3'b000};
    for (int i = 0; i < 128; i++) tail[i] = (i < hash_fill) ? hash_block[i] : 8'h00;
    tail[hash_fill] = sha256_pkg::PAD_BYTE;
    for (int i = 0; i < 8; i++)
      tail[(two_blocks ? 120 : 56) + i] = bit_len[63-8*i -: 8];
    for (int i = 0; i < 64; i++) half[i] = tail[i];
    compress_block(half);
    if (two_blocks) begin
      for (int i = 0; i < 64; i++) half[i] = tail[64+i];
      compress_block(half);
    end
    for (int i = 0; i < 8; i++) begin
      d.digest_word = hash_chain[i];
      d.word_index = 3'(i);
      d.last_word = (i == 7);
      digest_expect.push_back(d);
    end
    restart_hash();
  endfunction

  task automatic push_word(input logic [7:0] b, input logic bv, input logic e);
    byte_item_t it;
    it.data_byte = b;
    it.byte_valid = bv;
    it.msg_end = e;
    word_backlog.push_back(it);
    item_total++;
  endtask

  // Random-content message of len bytes with occasional empty words mixed in.
  // The end marker rides on the last byte or comes as a word of its own.
  task automatic push_message(input int len);
    bit end_on_byte;
    end_on_byte = (len > 0) && ($urandom_range(1, 0) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(7, 0) == 0) push_word(8'($urandom), 1'b0, 1'b0);
      push_word(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
    end
    if (!end_on_byte) push_word(8'($urandom), 1'b0, 1'b1);
    msg_total++;
  endtask

  // Driver: the model is advanced at the edge where a word is accepted.
  always @(posedge clk) begin
    byte_item_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_word('{s_axis_tdata, s_axis_tuser, s_axis_tlast});
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (word_backlog.size() > 0) begin
          nxt = word_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= nxt.data_byte;
          s_axis_tuser <= nxt.byte_valid;
          s_axis_tlast <= nxt.msg_end;
          // Idle bursts only while plenty of stimulus remains.
          if (word_backlog.size() > 60 && $urandom_range(5, 0) == 0)
            send_gap = $urandom_range(10, 1);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, and each taken word is checked in order.
  always @(posedge clk) begin
    digest_out_t exp_w;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (digest_expect.size() == 0) begin
          $error("unexpected digest word %h", m_axis_tdata);
          fail_count++;
        end else begin
          exp_w = digest_expect.pop_front();
          if (m_axis_tdata !== exp_w.digest_word) begin
            $error("digest_word expected %h got %h", exp_w.digest_word, m_axis_tdata);
            fail_count++;
          end
          if (m_axis_tuser !== exp_w.word_index) begin
            $error("word_index expected %0d got %0d", exp_w.word_index, m_axis_tuser);
            fail_count++;
          end
          if (m_axis_tlast !== exp_w.last_word) begin
            $error("last_word expected %0d got %0d", exp_w.last_word, m_axis_tlast);
            fail_count++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (word_backlog.size() > 60 && $urandom_range(4, 0) == 0)
          recv_gap = $urandom_range(10, 1);
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** sha256_stream_hasher_top: FAILED **");
      $finish;
    end
  end

  initial begin
    int pick;
    restart_hash();
    for (int i = 0; i < 64; i++) hash_block[i] = 8'h00;

    // Directed: empty message, a lone all-ones byte with the end marker,
    // "abc" with empty words carrying both data extremes and a trailing
    // end-only word, and a lone zero byte with the end marker.
    push_word(8'h00, 1'b0, 1'b1);
    push_word(8'hff, 1'b1, 1'b1);
    push_word(8'h61, 1'b1, 1'b0);
    push_word(8'h00, 1'b0, 1'b0);
    push_word(8'h62, 1'b1, 1'b0);
    push_word(8'hff, 1'b0, 1'b0);
    push_word(8'h63, 1'b1, 1'b0);
    push_word(8'h00, 1'b0, 1'b1);
    push_word(8'h00, 1'b1, 1'b1);
    msg_total += 4;

    // Random: mostly short messages, with some right at the padding and
    // block boundaries so one and two final blocks both occur.
    while (item_total < 210 || msg_total < 12) begin
      pick = $urandom_range(9, 0);
      if (pick < 7) begin
        push_message($urandom_range(12, 0));
      end else begin
        case ($urandom_range(5, 0))
          0: push_message(55);
          1: push_message(56);
          2: push_message(63);
          3: push_message(64);
          4: push_message(65);
          default: push_message(119 + $urandom_range(2, 0));
        endcase
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (word_backlog.size() > 0 || s_axis_tvalid) @(posedge clk);
    while (digest_expect.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && digest_expect.size() == 0) begin
      $display("** sha256_stream_hasher_top: PASSED **");
    end else begin
      $display("** sha256_stream_hasher_top: FAILED **");
    end
    $finish;
  end

endmodule
